// ----- rtl/lfu_pkg.sv -----
// Package: shared types, constants and codes for the LFU cache core.
package lfu_pkg;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W   = 32;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 16;
  localparam int STAMP_W = 32;
  localparam int CAP_W   = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic KIND_GET = 1'b0;
  localparam logic KIND_PUT = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [KEY_W-1:0]  key;
    logic signed [DATA_W-1:0] value;
  } lfu_req_t;

  typedef struct packed {
    logic              hit;
    logic signed [DATA_W-1:0] read_value;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
  } lfu_rsp_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load_req;     // capture request, reset scan index
    logic scan_key;     // compare one entry against the key
    logic scan_vic;     // compare one entry for victim
    logic step;         // advance scan index
    logic do_hit;       // apply hit update to found entry
    logic do_evict;     // invalidate victim
    logic do_insert;    // write new entry at free slot
    logic load_rsp;     // latch response fields
  } lfu_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic last;         // scan index at final entry
    logic found;        // key match seen
    logic full;         // occupancy >= effective capacity
    logic cap_zero;     // effective capacity is zero
    logic is_put;
    logic vic_ok;       // a victim was found
    logic free_ok;      // a free slot exists
  } lfu_sts_t;
endpackage

// ----- rtl/lfu_ctrl.sv -----
// Controller: sequences key search, victim search and entry updates.
module lfu_ctrl import lfu_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lfu_sts_t sts,
  output lfu_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_KEY  = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_VIC  = 3'd3;
  localparam logic [2:0] S_INS  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;
  logic       out_valid_next;

  // The response register frees only when taken, so a new request enters
  // only while no response waits, and so it cannot overwrite one.
  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          state_next = S_KEY;
        end
      end
      S_KEY: begin
        cmd.scan_key = 1'b1;
        cmd.step = 1'b1;
        if (sts.last) state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.is_put && sts.cap_zero) begin
          state_next = S_OUT;
        end else if (sts.found) begin
          cmd.do_hit = 1'b1;
          state_next = S_OUT;
        end else if (!sts.is_put) begin
          state_next = S_OUT;
        end else if (sts.full) begin
          state_next = S_VIC;
        end else begin
          state_next = S_INS;
        end
      end
      S_VIC: begin
        cmd.scan_vic = 1'b1;
        cmd.step = 1'b1;
        if (sts.last) state_next = S_INS;
      end
      S_INS: begin
        cmd.do_evict = sts.vic_ok;
        cmd.do_insert = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.load_rsp = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

// ----- rtl/lfu_dp.sv -----
// Datapath: entry store, scan index, comparators and response register.
module lfu_dp import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  lfu_req_t         req,
  input  lfu_cmd_t         cmd,
  output lfu_sts_t         sts,
  output lfu_rsp_t         rsp
);
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [KEY_W-1:0]   entry_key   [MAX_ENTRIES];
  logic [DATA_W-1:0]  entry_data  [MAX_ENTRIES];
  logic [COUNT_W-1:0] use_count   [MAX_ENTRIES];
  logic [STAMP_W-1:0] count_stamp [MAX_ENTRIES];

  logic [STAMP_W-1:0] access_clock;
  logic [OCC_W-1:0]   occupancy;
  logic [CAP_W-1:0]   capacity;
  lfu_req_t           req_q;
  logic [IDX_W-1:0]   idx;
  logic               found;
  logic [IDX_W-1:0]   found_idx;
  logic               vic_ok;
  logic [IDX_W-1:0]   vic_idx;
  logic [COUNT_W-1:0] vic_cnt;
  logic [STAMP_W-1:0] vic_stamp;
  logic               free_ok;
  logic [IDX_W-1:0]   free_idx;
  logic [DATA_W-1:0]  hit_data;
  logic [KEY_W-1:0]   vic_key;
  logic [CMP_W-1:0]   cap_eff;
  logic [STAMP_W-1:0] stamp_diff;
  logic               better;
  logic [IDX_W-1:0]   ins_idx;

  always_comb begin
    if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) cap_eff = CMP_W'(MAX_ENTRIES);
    else cap_eff = CMP_W'(capacity);
  end

  assign stamp_diff = count_stamp[idx] - vic_stamp;
  assign better = !vic_ok || (use_count[idx] < vic_cnt) ||
                  ((use_count[idx] == vic_cnt) && stamp_diff[STAMP_W-1]);
  // Evicting frees the victim; the lowest free slot is then the lower of both.
  assign ins_idx = (vic_ok && (!free_ok || vic_idx < free_idx)) ? vic_idx : free_idx;

  assign sts.last     = (idx == IDX_W'(MAX_ENTRIES - 1));
  assign sts.found    = found;
  assign sts.full     = CMP_W'(occupancy) >= cap_eff;
  assign sts.cap_zero = (cap_eff == '0);
  assign sts.is_put   = (req_q.kind == KIND_PUT);
  assign sts.vic_ok   = vic_ok;
  assign sts.free_ok  = free_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid  <= '0;
      access_clock <= '0;
      occupancy    <= '0;
    end else begin
      if (cmd.do_hit) begin
        entry_valid[found_idx] <= 1'b1;
        access_clock <= access_clock + 1'b1;
      end
      if (cmd.do_insert && (vic_ok || free_ok)) begin
        // Drop the victim unless the new entry lands in its slot.
        if (cmd.do_evict && (vic_idx != ins_idx)) entry_valid[vic_idx] <= 1'b0;
        entry_valid[ins_idx] <= 1'b1;
        access_clock <= access_clock + 1'b1;
        if (!(cmd.do_evict)) occupancy <= occupancy + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
      idx <= '0;
      found <= 1'b0;
      found_idx <= '0;
      vic_ok <= 1'b0;
      vic_idx <= '0;
      vic_cnt <= '0;
      vic_stamp <= '0;
      free_ok <= 1'b0;
      free_idx <= '0;
      hit_data <= '0;
      vic_key <= '0;
    end else if (cmd.step) begin
      idx <= sts.last ? '0 : idx + 1'b1;
    end
    if (cmd.scan_key) begin
      if (entry_valid[idx] && !found && entry_key[idx] == req_q.key) begin
        found <= 1'b1;
        found_idx <= idx;
        hit_data <= entry_data[idx];
      end
      if (!entry_valid[idx] && !free_ok) begin
        free_ok <= 1'b1;
        free_idx <= idx;
      end
    end
    if (cmd.scan_vic && entry_valid[idx] && better) begin
      vic_ok <= 1'b1;
      vic_idx <= idx;
      vic_cnt <= use_count[idx];
      vic_stamp <= count_stamp[idx];
      vic_key <= entry_key[idx];
    end
    if (cmd.do_hit) begin
      if (use_count[found_idx] != COUNT_MAX)
        use_count[found_idx] <= use_count[found_idx] + 1'b1;
      count_stamp[found_idx] <= access_clock;
      if (req_q.kind == KIND_PUT) entry_data[found_idx] <= req_q.value;
    end
    if (cmd.do_insert && (vic_ok || free_ok)) begin
      entry_key[ins_idx]   <= req_q.key;
      entry_data[ins_idx]  <= req_q.value;
      use_count[ins_idx]   <= COUNT_W'(1);
      count_stamp[ins_idx] <= access_clock;
    end
    if (cmd.load_rsp) begin
      rsp.hit <= found && !(sts.is_put && sts.cap_zero);
      rsp.read_value <= (found && !sts.is_put) ? hit_data : '0;
      rsp.evicted <= sts.is_put && !found && vic_ok && !sts.cap_zero;
      rsp.evicted_key <= (sts.is_put && !found && vic_ok && !sts.cap_zero) ? vic_key : '0;
    end
  end
endmodule

// ----- rtl/lfu_cache_replacement_core.sv -----
// Top level: LFU key-value cache with LRU tie-break, controller plus datapath.
// Each request first scans the entry store for the key, one entry per cycle,
// then decides and responds. A put of a new key into a store with room also
// writes the entry, and a put of a new key into a full store first runs a
// second one-entry-per-cycle scan that finds the victim with the lowest use
// count, oldest stamp on a tie, and then writes the entry. One request is in
// flight at a time; a new request is taken once the previous response has
// been accepted. Capacity is written through cfg_we/cfg_data by the user, who
// must write it only while the core is idle; the core has no check for this.
// Values above MAX_ENTRIES act as MAX_ENTRIES and zero makes every put a no-op.
module lfu_cache_replacement_core import lfu_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  lfu_req_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lfu_rsp_t         out_data
);
  lfu_cmd_t cmd;
  lfu_sts_t sts;

  lfu_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  lfu_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(in_data), .cmd(cmd), .sts(sts), .rsp(out_data)
  );

  // Never accept a request while a response is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("request accepted over pending response");

  // An eviction is only ever reported alongside a miss.
  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evicted) |-> !out_data.hit)
    else $error("eviction reported on a hit");

  // An evicting put never returns read data.
  a_zero_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evicted) |-> (out_data.read_value == '0))
    else $error("read data on evicting put");
endmodule

// ----- tb/tb_lfu_cache_replacement_core.sv -----
// Testbench for the LFU cache core: directed and random requests checked by a scoreboard.
module tb_lfu_cache_replacement_core;
  import lfu_pkg::*;

  localparam int DEPTH = MAX_ENTRIES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;

  // Scoreboard: holds its own copy of the cache state and predicts each response.
  class lfu_scoreboard;
    bit                   slot_valid[DEPTH];
    logic [KEY_W-1:0]     slot_key[DEPTH];
    logic [DATA_W-1:0]    slot_data[DEPTH];
    logic [COUNT_W-1:0]   slot_count[DEPTH];
    logic [STAMP_W-1:0]   slot_stamp[DEPTH];
    logic [STAMP_W-1:0]   access_clock;
    int                   occupancy;
    int                   capacity;
    lfu_rsp_t             pending[$];
    int                   errors;

    function void clear();
      foreach (slot_valid[i]) slot_valid[i] = 0;
      access_clock = '0;
      occupancy = 0;
      capacity = CAP_RESET;
      pending.delete();
      errors = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] cap);
      capacity = (cap > DEPTH) ? DEPTH : cap;
    endfunction

    function void touch(int i, bit bump);
      if (bump && slot_count[i] != COUNT_MAX) slot_count[i] = slot_count[i] + 1'b1;
      slot_stamp[i] = access_clock;
      access_clock = access_clock + 1'b1;
    endfunction

    function int find_key(logic [KEY_W-1:0] k);
      for (int i = 0; i < DEPTH; i++)
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function int find_victim();
      int best;
      logic [STAMP_W-1:0] diff;
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!slot_valid[i]) continue;
        diff = slot_stamp[i] - (best < 0 ? '0 : slot_stamp[best]);
        if (best < 0 || slot_count[i] < slot_count[best] ||
            (slot_count[i] == slot_count[best] && diff[STAMP_W-1]))
          best = i;
      end
      return best;
    endfunction

    // Note an accepted request: apply it and queue the predicted response.
    function void note_request(lfu_req_t r);
      lfu_rsp_t p;
      int idx, v, slot;
      p = '0;
      idx = find_key(r.key);
      if (r.kind == KIND_GET) begin
        if (idx >= 0) begin
          p.hit = 1;
          p.read_value = slot_data[idx];
          touch(idx, 1);
        end
      end else if (capacity != 0) begin
        if (idx >= 0) begin
          p.hit = 1;
          slot_data[idx] = r.value;
          touch(idx, 1);
        end else begin
          if (occupancy >= capacity) begin
            v = find_victim();
            if (v >= 0) begin
              p.evicted = 1;
              p.evicted_key = slot_key[v];
              slot_valid[v] = 0;
              occupancy--;
            end
          end
          slot = -1;
          for (int i = 0; i < DEPTH; i++)
            if (!slot_valid[i]) begin
              slot = i;
              break;
            end
          if (slot >= 0) begin
            slot_valid[slot] = 1;
            slot_key[slot] = r.key;
            slot_data[slot] = r.value;
            slot_count[slot] = 1;
            touch(slot, 0);
            occupancy++;
          end
        end
      end
      pending.push_back(p);
    endfunction

    // Check an accepted response against the oldest prediction.
    function void check_response(lfu_rsp_t got);
      lfu_rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $display("%0t: hit expected %0b actual %0b", $time, exp.hit, got.hit);
        errors++;
      end
      if (got.read_value !== exp.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, exp.read_value,
                 got.read_value);
        errors++;
      end
      if (got.evicted !== exp.evicted) begin
        $display("%0t: evicted expected %0b actual %0b", $time, exp.evicted, got.evicted);
        errors++;
      end
      if (got.evicted_key !== exp.evicted_key) begin
        $display("%0t: evicted_key expected %h actual %h", $time, exp.evicted_key,
                 got.evicted_key);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  lfu_req_t         in_data;
  logic             out_valid;
  logic             out_ready;
  lfu_rsp_t         out_data;

  lfu_scoreboard    cache_sb;
  int               idle_cycles;
  bit               timed_out;
  bit               no_stall;
  logic [KEY_W-1:0] key_pool[8];

  lfu_cache_replacement_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Sample both handshakes at the edge; predict on request, check on response.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) cache_sb.note_request(in_data);
      if (out_valid && out_ready) cache_sb.check_response(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("lfu_cache_replacement_core test failed");
        $finish;
      end
    end
  end

  // Response side: draw a stall per response, sometimes run with no stalls.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (no_stall) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
      end
    end
  end

  // Send one request: gap, raise valid, hold until accepted.
  // Valid stays high after the accepting edge; the next gap or idle drops it.
  task automatic send_request(logic kind, logic [KEY_W-1:0] key, logic [DATA_W-1:0] value);
    lfu_req_t r;
    int gap;
    r.kind = kind;
    r.key = key;
    r.value = value;
    gap = no_stall ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Write capacity once every response is back and the core has settled.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    in_valid <= 1'b0;
    while (cache_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= cap;
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_sb.set_capacity(cap);
  endtask

  task automatic random_phase(int count);
    logic [KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      // Draw mostly from a small key pool so hits, updates and evictions occur.
      if ($urandom_range(0, 9) < 8) k = key_pool[$urandom_range(0, 7)] ^ $urandom_range(0, 15);
      else k = $urandom();
      send_request(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  initial begin
    cache_sb = new();
    cache_sb.clear();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    idle_cycles = 0;
    timed_out = 0;
    no_stall = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: miss on empty store, extreme keys and values, update, hit.
    send_request(KIND_GET, 32'h0, 32'h0);
    send_request(KIND_PUT, 32'h0, 32'h8000_0000);
    send_request(KIND_PUT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    send_request(KIND_GET, 32'hFFFF_FFFF, 32'h0);
    send_request(KIND_PUT, 32'h0, 32'hFFFF_FFFF);
    send_request(KIND_GET, 32'h0, 32'h1234_5678);
    // Fill a small store and force evictions.
    write_capacity(5'd2);
    send_request(KIND_PUT, 32'hA5A5_5A5A, 32'h1);
    send_request(KIND_PUT, 32'h5A5A_A5A5, 32'h2);
    send_request(KIND_GET, 32'h5A5A_A5A5, 32'h0);
    send_request(KIND_PUT, 32'h1111_1111, 32'h3);
    // Capacity zero: puts do nothing, gets still search.
    write_capacity(5'd0);
    send_request(KIND_PUT, 32'h1111_1111, 32'h9);
    send_request(KIND_PUT, 32'h2222_2222, 32'h9);
    send_request(KIND_GET, 32'h1111_1111, 32'h0);
    // Raise above the entry count: treated as the full depth.
    write_capacity(5'd31);
    for (int i = 0; i < 18; i++) send_request(KIND_PUT, 32'h100 + i, i);

    // Random phases over several capacities, the extremes among them.
    write_capacity(5'd16);
    random_phase(200);
    write_capacity(5'd1);
    random_phase(120);
    no_stall = 1;
    write_capacity(5'd4);
    random_phase(150);
    no_stall = 0;
    write_capacity(5'd0);
    random_phase(60);
    write_capacity(5'd9);
    random_phase(170);
    write_capacity(5'd31);
    random_phase(150);

    in_valid <= 1'b0;
    while (cache_sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (cache_sb.errors == 0) $display("lfu_cache_replacement_core test passed");
    else $display("lfu_cache_replacement_core test failed");
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/lfu_pkg.sv
rtl/lfu_ctrl.sv
rtl/lfu_dp.sv
rtl/lfu_cache_replacement_core.sv
tb/tb_lfu_cache_replacement_core.sv
